@@ hdl/ahdlc_pkg.sv @@
// Package for the asynchronous HDLC frame decoder.
// Holds the framing constants, status codes, shared structs and the FCS-16 byte update.
// No dependencies.
`default_nettype none

package ahdlc_pkg;

    localparam logic [7:0]  FLAG_BYTE        = 8'h7E;
    localparam logic [7:0]  ESC_BYTE         = 8'h7D;
    localparam logic [7:0]  ESC_MASK         = 8'h20;
    localparam logic [15:0] FCS_INIT         = 16'hFFFF;
    localparam logic [15:0] FCS_GOOD         = 16'hF0B8;
    localparam logic [15:0] FCS_POLY         = 16'h8408;
    localparam logic [15:0] FCS_BYTES        = 16'd2;
    localparam logic [15:0] BUFFER_SIZE_RST  = 16'd4096;

    typedef enum logic [2:0] {
        ST_NONE        = 3'd0,
        ST_GOOD        = 3'd1,
        ST_FCS_ERR     = 3'd2,
        ST_ESC_DISCARD = 3'd3,
        ST_BUF_FULL    = 3'd4
    } t_status;

    typedef struct packed {
        logic        hunting;
        logic        esc_pending;
        logic [15:0] byte_count;
        logic [15:0] fcs;
    } t_frame_state;

    typedef struct packed {
        t_status     status;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [15:0] data_index;
        logic [15:0] info_len;
    } t_result;

    // Reflected CRC-16 update over one byte, least significant bit first.
    function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] v;
        v = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ FCS_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hdl/ahdlc_step.sv @@
// Combinational step logic of the HDLC frame decoder: one raw byte against the frame state.
// Produces the next frame state and the result item. Depends on ahdlc_pkg.
`default_nettype none

module ahdlc_step import ahdlc_pkg::*; (
    input  wire logic [7:0]   i_byte,
    input  wire logic [15:0]  i_buffer_size,
    input  wire t_frame_state i_state,
    output t_frame_state      o_state,
    output t_result           o_result
);

    logic       w_is_flag;
    logic       w_is_esc;
    logic       w_esc_ok;
    logic [7:0] w_data;

    assign w_is_flag = (i_byte == FLAG_BYTE);
    assign w_is_esc  = (i_byte == ESC_BYTE);
    // Only stuffed flag and stuffed escape are legal after an escape.
    assign w_esc_ok  = (i_byte == (FLAG_BYTE ^ ESC_MASK)) || (i_byte == (ESC_BYTE ^ ESC_MASK));
    assign w_data    = i_state.esc_pending ? (i_byte ^ ESC_MASK) : i_byte;

    always_comb begin
        o_state  = i_state;
        o_result = '{status: ST_NONE, data_valid: 1'b0, data_byte: 8'h00,
                     data_index: 16'h0000, info_len: 16'h0000};
        priority if (i_state.hunting && !w_is_flag) begin
            o_state.byte_count = '0;
            o_state.fcs        = FCS_INIT;
        end else if (w_is_flag) begin
            o_state.hunting = 1'b0;
            if (i_state.byte_count > FCS_BYTES) begin
                if (i_state.fcs == FCS_GOOD) begin
                    o_result.status   = ST_GOOD;
                    o_result.info_len = i_state.byte_count - FCS_BYTES;
                end else begin
                    o_result.status = ST_FCS_ERR;
                end
            end
            o_state.byte_count = '0;
            o_state.fcs        = FCS_INIT;
        end else if (w_is_esc) begin
            if (!i_state.esc_pending) begin
                o_state.esc_pending = 1'b1;
            end else begin
                o_state.esc_pending = 1'b0;
                o_state.hunting     = 1'b1;
                o_state.byte_count  = '0;
                o_state.fcs         = FCS_INIT;
                o_result.status     = ST_ESC_DISCARD;
            end
        end else if (i_state.byte_count >= i_buffer_size) begin
            // The pending escape survives an overflow on purpose.
            o_state.hunting    = 1'b1;
            o_state.byte_count = '0;
            o_state.fcs        = FCS_INIT;
            o_result.status    = ST_BUF_FULL;
        end else if (i_state.esc_pending && !w_esc_ok) begin
            o_state.esc_pending = 1'b0;
            o_state.hunting     = 1'b1;
            o_state.byte_count  = '0;
            o_state.fcs         = FCS_INIT;
            o_result.status     = ST_ESC_DISCARD;
        end else begin
            o_state.esc_pending = 1'b0;
            o_state.byte_count  = i_state.byte_count + 16'd1;
            o_state.fcs         = fcs_update(i_state.fcs, w_data);
            o_result.data_valid = 1'b1;
            o_result.data_byte  = w_data;
            o_result.data_index = i_state.byte_count;
        end
    end

endmodule

`default_nettype wire

@@ hdl/async_hdlc_frame_decoder_core.sv @@
// An accepted item is held in the input register; its result item is loaded into the output
// register when that is free. Throughput: one item per cycle while results are taken.
// The running FCS update and escape logic sit in one stage.
// Reset (synchronous, active low): hunting for a flag, no escape pending, byte count zero,
// FCS 0xFFFF, buffer size 4096, both pipeline registers empty.
// Top level of the async HDLC deframer; depends on ahdlc_pkg and ahdlc_step.
`default_nettype none

module async_hdlc_frame_decoder_core import ahdlc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel: buffer size in bytes, FCS included.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    // Raw line byte input.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    // Result item output.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic             o_data_valid,
    output logic [7:0]       o_data_byte,
    output logic [15:0]      o_data_index,
    output logic [15:0]      o_info_len
);

    // The buffer size register. The user must make writes only while the block is idle; the block
    // does not enforce this, and the port is always ready.
    logic [15:0]  r_buffer_size;

    // Input register holding one raw byte until the step logic consumes it.
    logic         r_in_valid;
    logic [7:0]   r_in_byte;

    // Frame state carried from one byte to the next.
    t_frame_state r_state;
    t_frame_state n_state;

    // Output register holding one result item until it is taken.
    logic         r_out_valid;
    t_result      r_result;
    t_result      n_result;

    // The held byte is processed whenever the output register is free or is
    // being emptied in this same cycle; a new item enters every cycle while results are taken.
    logic         w_process;

    assign w_process   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_process;
    assign o_cfg_ready = 1'b1;

    ahdlc_step u_step (
        .i_byte        (r_in_byte),
        .i_buffer_size (r_buffer_size),
        .i_state       (r_state),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= BUFFER_SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_buffer_size <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Frame state only advances when a byte is actually processed, so stalls on the
    // output side leave it untouched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{hunting: 1'b1, esc_pending: 1'b0, byte_count: 16'h0000,
                         fcs: FCS_INIT};
        end else if (w_process) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_process) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_result.status;
    assign o_data_valid = r_result.data_valid;
    assign o_data_byte  = r_result.data_byte;
    assign o_data_index = r_result.data_index;
    assign o_info_len   = r_result.info_len;

`ifndef SYNTHESIS
    // A discard of either kind must leave the frame state back in hunt with nothing stored.
    a_discard_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_process && (n_result.status == ST_ESC_DISCARD || n_result.status == ST_BUF_FULL)
        |=> r_state.hunting && (r_state.byte_count == 16'h0000) && (r_state.fcs == FCS_INIT))
        else $error("discard did not return the frame state to hunt");

    // Every stored byte advances the byte count by exactly one.
    a_count_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_process && n_result.data_valid
        |=> r_state.byte_count == 16'($past(r_state.byte_count) + 16'd1))
        else $error("byte count did not follow a stored byte");

    // A stored byte never lands beyond the configured buffer.
    a_index_in_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_data_valid |-> o_data_index < r_buffer_size)
        else $error("stored byte index beyond buffer size");

    // Data and frame completion are never reported in the same result item.
    a_data_excl_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_data_valid |-> o_status == ST_NONE)
        else $error("stored byte reported together with a frame status");
`endif

endmodule

`default_nettype wire

@@ sim/tb_async_hdlc_frame_decoder_core.sv @@
// Self-checking testbench for the async HDLC frame decoder core: a byte driver, a result monitor
// and a behavioural deframer that predicts every result item.
// Depends on ahdlc_pkg (framing constants, status codes) and async_hdlc_frame_decoder_core.
module tb_async_hdlc_frame_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ahdlc_pkg::*;

    // The slowest correct run is roughly 1300 items when both sides idle heavily, so this
    // ceiling leaves a wide margin while still catching a hung block.
    localparam int CYCLE_LIMIT     = 400000;
    // Spare cycles after draining let a stray late result show up before the next register
    // write or the end of the run.
    localparam int DRAIN_CYCLES    = 6;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 150;

    typedef enum int {
        SEQ_GOOD,
        SEQ_BAD_FCS,
        SEQ_BAD_ESC,
        SEQ_DOUBLE_ESC,
        SEQ_ESC_AT_CLOSE
    } t_seq_kind;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        t_status    status;
        bit         data_valid;
        bit [7:0]   data_byte;
        bit [15:0]  data_index;
        bit [15:0]  info_len;
    } t_deframe_result;

    // Every input is given a known value from time zero.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = '0;
    logic        i_out_ready = 1'b0;

    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic        o_data_valid;
    logic [7:0]  o_data_byte;
    logic [15:0] o_data_index;
    logic [15:0] o_info_len;

    async_hdlc_frame_decoder_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_data_valid (o_data_valid),
        .o_data_byte  (o_data_byte),
        .o_data_index (o_data_index),
        .o_info_len   (o_info_len)
    );

    always #5ns i_clk = ~i_clk;

    // Line bytes waiting to be offered, and the result items the deframer expects, oldest first.
    bit [7:0]        line_bytes[$];
    t_deframe_result expected_results[$];
    // Scratch buffer for the unstuffed content of the next frame to be built.
    bit [7:0]        payload_buf[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;

    // Deframer state as it stands after reset.  The buffer limit only changes through the
    // configuration channel, and only while the block is idle.
    bit        frame_hunting     = 1'b1;
    bit        frame_esc_pending = 1'b0;
    bit [15:0] frame_stored      = '0;
    bit [15:0] frame_fcs         = FCS_INIT;
    bit [15:0] buffer_limit      = BUFFER_SIZE_RST;

    // FCS-16 over one octet, bit by bit with the feedback taken from the incoming data bit.
    function automatic bit [15:0] fcs16_octet(bit [15:0] crc, bit [7:0] octet);
        bit [15:0] acc;
        bit        feedback;
        acc = crc;
        for (int k = 0; k < 8; k++) begin
            feedback = acc[0] ^ octet[k];
            acc = {1'b0, acc[15:1]};
            if (feedback) begin
                acc = acc ^ FCS_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void restart_frame();
        frame_stored = '0;
        frame_fcs    = FCS_INIT;
    endfunction

    // Advances the deframer by one line byte and returns the result item it should produce.
    // Note that neither a flag nor a buffer overflow clears a pending escape.
    function automatic t_deframe_result deframe_step(bit [7:0] rx);
        t_deframe_result res;
        bit [7:0]        octet;
        res.status     = ST_NONE;
        res.data_valid = 1'b0;
        res.data_byte  = '0;
        res.data_index = '0;
        res.info_len   = '0;
        octet          = rx;
        if (frame_hunting && octet != FLAG_BYTE) begin
            restart_frame();
        end else if (octet == FLAG_BYTE) begin
            frame_hunting = 1'b0;
            if (frame_stored > FCS_BYTES) begin
                if (frame_fcs == FCS_GOOD) begin
                    res.status   = ST_GOOD;
                    res.info_len = frame_stored - FCS_BYTES;
                end else begin
                    res.status = ST_FCS_ERR;
                end
            end
            restart_frame();
        end else if (octet == ESC_BYTE) begin
            if (!frame_esc_pending) begin
                frame_esc_pending = 1'b1;
            end else begin
                frame_esc_pending = 1'b0;
                frame_hunting     = 1'b1;
                restart_frame();
                res.status = ST_ESC_DISCARD;
            end
        end else if (frame_stored >= buffer_limit) begin
            frame_hunting = 1'b1;
            restart_frame();
            res.status = ST_BUF_FULL;
        end else if (frame_esc_pending && octet != (FLAG_BYTE ^ ESC_MASK)
                     && octet != (ESC_BYTE ^ ESC_MASK)) begin
            frame_esc_pending = 1'b0;
            frame_hunting     = 1'b1;
            restart_frame();
            res.status = ST_ESC_DISCARD;
        end else begin
            if (frame_esc_pending) begin
                frame_esc_pending = 1'b0;
                octet = octet ^ ESC_MASK;
            end
            res.data_valid = 1'b1;
            res.data_byte  = octet;
            res.data_index = frame_stored;
            frame_fcs      = fcs16_octet(frame_fcs, octet);
            frame_stored   = frame_stored + 16'd1;
        end
        return res;
    endfunction

    // Payload bytes lean towards the flag and escape values so that stuffing is exercised often.
    function automatic bit [7:0] random_payload_byte();
        case ($urandom_range(9))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void push_stuffed(bit [7:0] octet);
        if (octet == FLAG_BYTE || octet == ESC_BYTE) begin
            line_bytes.push_back(ESC_BYTE);
            line_bytes.push_back(octet ^ ESC_MASK);
        end else begin
            line_bytes.push_back(octet);
        end
    endfunction

    // Turns payload_buf into a stuffed frame with its FCS and a closing flag.  The kind selects
    // an optional fault: a flipped bit anywhere in the frame, an illegal escape sequence or a
    // double escape at a random place, or a lone escape just before the closing flag.
    function automatic void queue_frame(t_seq_kind kind, bit open_flag);
        bit [7:0]    body[$];
        bit [15:0]   crc;
        bit [7:0]    odd_byte;
        int unsigned fault_at;
        crc  = FCS_INIT;
        body = payload_buf;
        foreach (payload_buf[k]) begin
            crc = fcs16_octet(crc, payload_buf[k]);
        end
        crc = ~crc;
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        fault_at = $urandom_range(body.size() - 1);
        if (kind == SEQ_BAD_FCS) begin
            body[fault_at] = body[fault_at] ^ (8'd1 << $urandom_range(7));
        end
        if (open_flag) begin
            line_bytes.push_back(FLAG_BYTE);
        end
        foreach (body[k]) begin
            if (k == fault_at && kind == SEQ_BAD_ESC) begin
                do begin
                    odd_byte = 8'($urandom_range(255));
                end while (odd_byte == (FLAG_BYTE ^ ESC_MASK) || odd_byte == (ESC_BYTE ^ ESC_MASK));
                line_bytes.push_back(ESC_BYTE);
                line_bytes.push_back(odd_byte);
            end else if (k == fault_at && kind == SEQ_DOUBLE_ESC) begin
                line_bytes.push_back(ESC_BYTE);
                line_bytes.push_back(ESC_BYTE);
            end
            push_stuffed(body[k]);
        end
        if (kind == SEQ_ESC_AT_CLOSE) begin
            line_bytes.push_back(ESC_BYTE);
        end
        line_bytes.push_back(FLAG_BYTE);
    endfunction

    // Mostly well-formed frames of random content, with noise, runt frames and faulty frames
    // mixed in.  Lengths are mostly short so that the small buffer limits overflow regularly.
    function automatic void queue_random_sequence();
        int unsigned len;
        bit          open_flag;
        open_flag = ($urandom_range(3) != 0);
        len = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(12);
        payload_buf.delete();
        for (int unsigned k = 0; k < len; k++) begin
            payload_buf.push_back(random_payload_byte());
        end
        case ($urandom_range(19))
            0, 1: begin
                // Line noise; it may itself hold a flag or an escape.
                repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(255)));
            end
            2:       queue_frame(SEQ_BAD_ESC, open_flag);
            3:       queue_frame(SEQ_DOUBLE_ESC, open_flag);
            4:       queue_frame(SEQ_ESC_AT_CLOSE, open_flag);
            5, 6:    queue_frame(SEQ_BAD_FCS, open_flag);
            7: begin
                // Runt frame of up to two bytes, which closes without any verdict.
                repeat ($urandom_range(2)) push_stuffed(8'($urandom_range(255)));
                line_bytes.push_back(FLAG_BYTE);
            end
            default: queue_frame(SEQ_GOOD, open_flag);
        endcase
    endfunction

    function automatic void set_idling(t_idle_mode mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct  = 74;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 74;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 31;
                recv_stall_pct = 31;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endfunction

    // Writes the buffer limit through the configuration channel, holding valid until accepted.
    task automatic write_buffer_size(bit [15:0] size);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        buffer_limit = size;
    endtask

    // Waits until every queued byte has been accepted and every result item has come back,
    // then gives the pipeline a few more cycles to show anything it should not produce.
    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (line_bytes.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Byte driver.  An accepted item is run through the deframer straight away, so its result
    // item is queued well before the block can offer it.  A new item is presented only when
    // the channel is free or the current item is being accepted at this edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(deframe_step(i_rx_byte));
            end
            if (!i_in_valid || o_in_ready) begin
                if (line_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_rx_byte  <= line_bytes.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: each accepted result item is compared field by field with the oldest
    // expectation.  Ready is re-drawn every cycle according to the current stall rate.
    always @(posedge i_clk) begin : result_monitor
        t_deframe_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result item with none expected: status %0d", o_status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    error_count++;
                end
                if (o_data_valid !== want.data_valid) begin
                    $error("data_valid: expected %0d, actual %0d", want.data_valid, o_data_valid);
                    error_count++;
                end
                if (o_data_byte !== want.data_byte) begin
                    $error("data_byte: expected 0x%02h, actual 0x%02h", want.data_byte, o_data_byte);
                    error_count++;
                end
                if (o_data_index !== want.data_index) begin
                    $error("data_index: expected %0d, actual %0d", want.data_index, o_data_index);
                    error_count++;
                end
                if (o_info_len !== want.info_len) begin
                    $error("info_len: expected %0d, actual %0d", want.info_len, o_info_len);
                    error_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: a run that has not finished by the limit has hung somewhere.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL async_hdlc_frame_decoder_core");
            $finish;
        end
    end

    // Test sequence: reset, a short directed burst under the reset buffer limit, then phases of
    // random traffic, each with its own buffer limit and idling pattern.  The limit is only
    // rewritten once the previous phase has fully drained.
    initial begin : stimulus
        bit [15:0] phase_sizes[NUM_PHASES];
        phase_sizes = '{BUFFER_SIZE_RST, 16'd0, 16'hFFFF, 16'd3, 16'd16, 16'd1, 16'd2, 16'd8};
        phase_sizes[NUM_PHASES - 1] = 16'($urandom_range(4, 48));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Extreme bytes while hunting are dropped; the flag then opens a frame.
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(FLAG_BYTE);
        // Good frame whose payload is one stuffed flag and one stuffed escape.
        payload_buf = '{FLAG_BYTE, ESC_BYTE};
        queue_frame(SEQ_GOOD, 1'b0);
        // Back-to-back flags, then a frame holding only its FCS: neither gives a verdict.
        line_bytes.push_back(FLAG_BYTE);
        payload_buf.delete();
        queue_frame(SEQ_GOOD, 1'b0);
        // Double escape discards the frame and returns to hunting.
        line_bytes.push_back(ESC_BYTE);
        line_bytes.push_back(ESC_BYTE);
        // Escape followed by an illegal byte does the same.
        line_bytes.push_back(FLAG_BYTE);
        line_bytes.push_back(ESC_BYTE);
        line_bytes.push_back(8'h22);
        // One-byte payload with a corrupted bit reports an FCS error.
        payload_buf = '{8'hA5};
        queue_frame(SEQ_BAD_FCS, 1'b1);
        // An escape survives a flag, so the first byte of the next frame is unstuffed.
        line_bytes.push_back(ESC_BYTE);
        line_bytes.push_back(FLAG_BYTE);
        line_bytes.push_back(ESC_BYTE ^ ESC_MASK);
        line_bytes.push_back(FLAG_BYTE);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                write_buffer_size(phase_sizes[p]);
                @(negedge i_clk);
            end
            set_idling(t_idle_mode'(p % 4));
            while (line_bytes.size() < ITEMS_PER_PHASE) begin
                queue_random_sequence();
            end
            wait_for_drain();
        end

        if (error_count == 0) begin
            $display("PASS async_hdlc_frame_decoder_core");
        end else begin
            $display("FAIL async_hdlc_frame_decoder_core");
        end
        $finish;
    end

endmodule
